### hdl/scalar_kalman_position_fuser_unit_assert.svh
// assertion macros shared by the position fuser files
`ifndef SCALAR_KALMAN_POSITION_FUSER_UNIT_ASSERT_SVH
`define SCALAR_KALMAN_POSITION_FUSER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SKPF_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("position fuser check failed");

// next-cycle implication, clocked on clk, off during reset
`define SKPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("position fuser check failed");

`endif

### hdl/skpf_pkg.sv
// widths, reset values, register indexes and saturation for the position fuser
`timescale 1ns / 1ps
package skpf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int STEP_W = 16;
	localparam int K_W = FRAC_BITS + 1;
	localparam int DEN_W = DATA_W + 1;
	localparam int MCAND_W = DATA_W + 2;
	localparam int MUL_W = (K_W > STEP_W) ? K_W : STEP_W;
	localparam int PROD_W = MCAND_W + MUL_W;
	localparam int SUM_W = DATA_W + 3;
	localparam int CNT_W = $clog2(MUL_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [K_W-1:0] K_ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DATA_W-1:0] PROC_NOISE_RESET = DATA_W'((64'd1 << FRAC_BITS) / 100);
	localparam logic [DATA_W-1:0] MEAS_NOISE_RESET = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic [STEP_W-1:0] STEP_TIME_RESET = STEP_W'(328);
	localparam logic [DATA_W-1:0] COV_RESET = DATA_W'(64'd1 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROCESS_NOISE = 2'd0,
		CFG_MEASURE_NOISE = 2'd1,
		CFG_STEP_TIME = 2'd2
	} cfg_idx_t;

	// clamp a wide signed sum to the signed data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[SUM_W-1:DATA_W-1] == '0 || x[SUM_W-1:DATA_W-1] == '1) begin
			r = x[DATA_W-1:0];
		end else if (x[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

### hdl/skpf_serial_mult.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
`timescale 1ns / 1ps
module skpf_serial_mult (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [skpf_pkg::MUL_W-1:0] multiplier,
	input  logic signed [skpf_pkg::MCAND_W-1:0] multiplicand,
	output logic busy,
	output logic signed [skpf_pkg::PROD_W-1:0] product
);
	import skpf_pkg::*;

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MUL_W-1:0] mplier_q;
	logic signed [MCAND_W-1:0] mcand_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] addend;

	// partial product for the current multiplier bit
	assign addend = mplier_q[MUL_W-1] ? PROD_W'(mcand_q) : '0;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(MUL_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// accumulate: shift left, add multiplicand when the bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= multiplicand;
			mplier_q <= multiplier;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1) + addend;
			mplier_q <= mplier_q << 1;
		end
	end

	assign busy = busy_q;
	assign product = acc_q;

endmodule

### hdl/skpf_serial_div.sv
// restoring divider for the gain, one quotient bit per cycle
`timescale 1ns / 1ps
module skpf_serial_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [skpf_pkg::DATA_W-1:0] num,
	input  logic [skpf_pkg::DEN_W-1:0] den,
	output logic busy,
	output logic [skpf_pkg::K_W-1:0] quot
);
	import skpf_pkg::*;

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [K_W-1:0] quot_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic ge;

	// first step weighs the integer bit, so no shift there
	assign trial = (cnt_q == CNT_W'(K_W)) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(K_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quot_q <= {quot_q[K_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

### hdl/scalar_kalman_position_fuser_unit.sv
// top level of the scalar kalman position fuser
// Usage:
// - input channel: in_valid / in_stall with position_sample and velocity_sample
//   (signed Q16.16); an item is taken when in_valid is high and in_stall low.
// - output channel: out_valid / out_stall with position_estimate, one result
//   per input item, in order.
// - config: cfg_write_en, cfg_index, cfg_data; index 0 process noise Q,
//   1 measurement noise R, 2 step time (Q0.16); other indexes are ignored.
//   Write only while the block is idle.
// - sequencing: each item runs two serial passes of 17 steps, in the
//   bit-serial multipliers and the gain divider, plus control states; a new
//   item is taken only once the last one has been written back.
// - the first pass runs the velocity product and the gain division side by
//   side, the second runs the correction and covariance products together.
// - a finished result sits in the output register; if the receiver stalls,
//   the next item is still accepted and computed, and only its final
//   write-back waits until the output register is free.
// - reset: estimate 0, covariance 1.0, velocity history 0, Q = 0.01,
//   R = 1.0, step time 328, no result pending.
`timescale 1ns / 1ps
`include "scalar_kalman_position_fuser_unit_assert.svh"
module scalar_kalman_position_fuser_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [skpf_pkg::DATA_W-1:0] position_sample,
	input  logic signed [skpf_pkg::DATA_W-1:0] velocity_sample,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [skpf_pkg::DATA_W-1:0] position_estimate,
	input  logic cfg_write_en,
	input  logic [skpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skpf_pkg::DATA_W-1:0] cfg_data
);
	import skpf_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_LOAD  = 9'b000000010,
		ST_MAC1  = 9'b000000100,
		ST_PREP1 = 9'b000001000,
		ST_PREP2 = 9'b000010000,
		ST_PREP3 = 9'b000100000,
		ST_MAC2  = 9'b001000000,
		ST_FIN1  = 9'b010000000,
		ST_FIN2  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [DATA_W-1:0] proc_noise_q;
	logic [DATA_W-1:0] meas_noise_q;
	logic [STEP_W-1:0] step_time_q;
	logic signed [DATA_W-1:0] est_q;
	logic [DATA_W-1:0] cov_q;
	logic signed [DATA_W-1:0] prev_vel_q;
	logic out_valid_q;
	logic signed [DATA_W-1:0] out_est_q;

	logic signed [DATA_W-1:0] meas_q;
	logic signed [DATA_W-1:0] vel_q;
	logic signed [DEN_W-1:0] vsum_q;
	logic [DATA_W-1:0] pp_q;
	logic den_zero_q;
	logic signed [MCAND_W-1:0] disp_q;
	logic [K_W-1:0] k_q;
	logic signed [DATA_W-1:0] xp_q;
	logic signed [MCAND_W-1:0] corr_q;
	logic [DATA_W-1:0] pn_q;

	logic accept;
	logic write_back;
	logic [DATA_W:0] pp_sum;
	logic [DEN_W-1:0] den;
	logic signed [MCAND_W-1:0] innov;
	logic signed [PROD_W-1:0] disp_round;
	logic signed [PROD_W-1:0] corr_round;
	logic signed [PROD_W-1:0] pn_round;
	logic signed [DATA_W-1:0] xn;

	logic mul_a_start;
	logic [MUL_W-1:0] mul_a_mplier;
	logic signed [MCAND_W-1:0] mul_a_mcand;
	logic mul_a_busy;
	logic signed [PROD_W-1:0] mul_a_prod;
	logic mul_b_start;
	logic [MUL_W-1:0] mul_b_mplier;
	logic signed [MCAND_W-1:0] mul_b_mcand;
	logic mul_b_busy;
	logic signed [PROD_W-1:0] mul_b_prod;
	logic div_start;
	logic div_busy;
	logic [K_W-1:0] div_quot;

	assign accept = (state_q == ST_IDLE) && in_valid;
	assign write_back = (state_q == ST_FIN2) && (!out_valid_q || !out_stall);

	// predicted covariance sum and gain denominator
	assign pp_sum = {1'b0, cov_q} + {1'b0, proc_noise_q};
	assign den = {1'b0, pp_q} + {1'b0, meas_noise_q};
	assign innov = MCAND_W'(meas_q) - MCAND_W'(xp_q);

	// round half up before the arithmetic shifts
	assign disp_round = mul_a_prod + (PROD_W'(1) <<< STEP_W);
	assign corr_round = mul_a_prod + (PROD_W'(1) <<< (FRAC_BITS - 1));
	assign pn_round = mul_b_prod + (PROD_W'(1) <<< (FRAC_BITS - 1));
	assign xn = sat_data(SUM_W'(xp_q) + SUM_W'(corr_q));

	// multiplier a: velocity product first, then the correction
	assign mul_a_start = (state_q == ST_LOAD) || (state_q == ST_PREP3);
	assign mul_a_mplier = (state_q == ST_LOAD) ? MUL_W'(step_time_q) : MUL_W'(k_q);
	assign mul_a_mcand = (state_q == ST_LOAD) ? MCAND_W'(vsum_q) : innov;

	// multiplier b: covariance scaling by one minus the gain
	assign mul_b_start = (state_q == ST_PREP3);
	assign mul_b_mplier = MUL_W'(K_ONE - k_q);
	assign mul_b_mcand = {{(MCAND_W - DATA_W){1'b0}}, pp_q};

	assign div_start = (state_q == ST_LOAD);

	skpf_serial_mult u_mul_a (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_a_start),
		.multiplier(mul_a_mplier),
		.multiplicand(mul_a_mcand),
		.busy(mul_a_busy),
		.product(mul_a_prod)
	);

	skpf_serial_mult u_mul_b (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_b_start),
		.multiplier(mul_b_mplier),
		.multiplicand(mul_b_mcand),
		.busy(mul_b_busy),
		.product(mul_b_prod)
	);

	skpf_serial_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(pp_q),
		.den(den),
		.busy(div_busy),
		.quot(div_quot)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_MAC1;
			ST_MAC1: begin
				if (!mul_a_busy && !div_busy) state_d = ST_PREP1;
			end
			ST_PREP1: state_d = ST_PREP2;
			ST_PREP2: state_d = ST_PREP3;
			ST_PREP3: state_d = ST_MAC2;
			ST_MAC2: begin
				if (!mul_a_busy && !mul_b_busy) state_d = ST_FIN1;
			end
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control, config and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			proc_noise_q <= PROC_NOISE_RESET;
			meas_noise_q <= MEAS_NOISE_RESET;
			step_time_q <= STEP_TIME_RESET;
			est_q <= '0;
			cov_q <= COV_RESET;
			prev_vel_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				unique case (cfg_index)
					CFG_PROCESS_NOISE: proc_noise_q <= cfg_data;
					CFG_MEASURE_NOISE: meas_noise_q <= cfg_data;
					CFG_STEP_TIME: step_time_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (write_back) begin
				est_q <= xn;
				cov_q <= pn_q;
				prev_vel_q <= vel_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers per step
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= position_sample;
			vel_q <= velocity_sample;
			vsum_q <= DEN_W'(prev_vel_q) + DEN_W'(velocity_sample);
			pp_q <= pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
		end
		if (state_q == ST_LOAD) begin
			den_zero_q <= (den == '0);
		end
		if (state_q == ST_PREP1) begin
			disp_q <= disp_round[STEP_W+1 +: MCAND_W];
			k_q <= den_zero_q ? '0 : div_quot;
		end
		if (state_q == ST_PREP2) begin
			xp_q <= sat_data(SUM_W'(est_q) + SUM_W'(disp_q));
		end
		if (state_q == ST_FIN1) begin
			corr_q <= corr_round[FRAC_BITS +: MCAND_W];
			pn_q <= pn_round[FRAC_BITS +: DATA_W];
		end
		if (write_back) begin
			out_est_q <= xn;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign position_estimate = out_est_q;

	`SKPF_ASSERT_IMPLIES(a_gain_range, state_q == ST_PREP2, k_q <= K_ONE)
	`SKPF_ASSERT_IMPLIES(a_units_idle, state_q == ST_IDLE, !mul_a_busy && !mul_b_busy && !div_busy)
	`SKPF_ASSERT_IMPLIES(a_cov_shrinks, state_q == ST_FIN2, pn_q <= pp_q)
	`SKPF_ASSERT_NEXT(a_result_loaded, write_back, out_valid_q && state_q == ST_IDLE)

endmodule
